// ===== rtl/frdm_pkg.sv =====
// Package for the frame ring descriptor manager: types, constants, codes.
`default_nettype none
package frdm_pkg;
  localparam int SLOT_DEPTH   = 16;
  localparam int DATA_DEPTH   = 4096;
  localparam int READER_COUNT = 4;
  localparam int SLOT_W       = 4;
  localparam int RDR_W        = 2;

  localparam logic [1:0] KIND_PUT    = 2'd0;
  localparam logic [1:0] KIND_GET    = 2'd1;
  localparam logic [1:0] KIND_FLUSH  = 2'd2;
  localparam logic [1:0] KIND_REOPEN = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MISSED   = 3'd1;
  localparam logic [2:0] ST_STALE    = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_BADLEN   = 3'd4;
  localparam logic [2:0] ST_INCONS   = 3'd5;

  localparam logic CFG_SLOTS = 1'b0;
  localparam logic CFG_BYTES = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  reader;
    logic [12:0] length;
    logic        want_last;
    logic        want_copy;
  } frdm_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] offset;
    logic [12:0] frame_len;
    logic [63:0] sequence_res;
    logic [4:0]  evicted;
  } frdm_out_t;

  typedef struct packed {
    logic [63:0] seq;
    logic [12:0] len;
    logic [11:0] off;
  } slot_t;

  // memory port bundle between controller and slot table
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    slot_t             wr_data;
  } slot_port_t;
endpackage
`default_nettype wire

// ===== rtl/frdm_slot_ram.sv =====
// Slot table: synchronous memory with valid bits and a registered read.
`default_nettype none
module frdm_slot_ram
  import frdm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       clear,
  input  wire slot_port_t port,
  output slot_t           rd_data
);
  slot_t                 mem [SLOT_DEPTH];
  logic [SLOT_DEPTH-1:0] vld_r;
  logic                  rvld_r;
  slot_t                 rraw_r;

  always_ff @(posedge clk) begin
    if (port.wr_en) mem[port.wr_addr] <= port.wr_data;
    if (port.rd_en) rraw_r <= mem[port.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (port.wr_en) vld_r[port.wr_addr] <= 1'b1;
      if (port.rd_en) rvld_r <= vld_r[port.rd_addr];
    end
  end

  assign rd_data = rvld_r ? rraw_r : '0;
endmodule
`default_nettype wire

// ===== rtl/frame_ring_descriptor_manager.sv =====
// Top level of the frame ring descriptor manager: control sequencer and state.
//
// Input channel in_valid/in_ready/in_data carries put, get, flush and reopen
// commands; each gives exactly one result on out_valid/out_ready/out_data.
// cfg_valid/cfg_ready/cfg_index/cfg_data writes frame_slots (0) or
// data_bytes (1); a write clamps the value and clears the ring and readers.
// One command is worked at a time. The slot table has a registered read, so
// each slot access takes a read state plus a decide state. A rejected put
// gets its result at the input transfer; flush and reopen pass through one
// result state; a get reads and decides a slot and reads again when the first
// slot read is not the one picked; a put reads and decides the head slot,
// then reads and decides each slot walked while evicting, and a put that
// commits adds a commit state. The walk is at most 15 slots at 16 slots; the
// eviction walk sets the worst case. The next input transfer waits until the
// result transfer has emptied the output register.
// A result sits in an output register and holds the input off until it is
// taken; a stalled receiver stalls the input. Synchronous active-low reset
// clears the ring (valid bits of the slot table cleared at once) and sets
// both registers to their largest values; no clearing pass is needed.
`default_nettype none
module frame_ring_descriptor_manager
  import frdm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire frdm_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output frdm_out_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_HRD   = 9'b000000010,
    S_HCHK  = 9'b000000100,
    S_WRD   = 9'b000001000,
    S_WCHK  = 9'b000010000,
    S_PCOM  = 9'b000100000,
    S_GRD   = 9'b001000000,
    S_GCHK  = 9'b010000000,
    S_GRES  = 9'b100000000
  } state_t;

  state_t st_r, st_nxt;
  frdm_in_t  cmd_r;
  frdm_out_t res_r;
  logic      ov_r;
  logic [4:0]  slots_r;
  logic [12:0] bytes_r;
  logic [SLOT_W-1:0] head_r, wi_r, ri_r;
  logic [4:0]  free_s_r, walk_r, ev_r;
  logic [11:0] wp_r;
  logic [12:0] free_b_r;
  logic [63:0] newest_r;
  logic [63:0] rseq_r [READER_COUNT];
  logic [SLOT_W-1:0] rnx_r [READER_COUNT];
  logic clear;
  slot_port_t port;
  slot_t rd;

  frdm_slot_ram u_ram (.clk(clk), .rst_n(rst_n), .clear(clear), .port(port),
                       .rd_data(rd));

  logic cfg_go, in_go;
  assign cfg_ready = (st_r == S_IDLE);
  assign in_ready  = (st_r == S_IDLE) && !ov_r && !cfg_valid;
  assign cfg_go    = cfg_valid && cfg_ready;
  assign in_go     = in_valid && in_ready;
  assign clear     = cfg_go;
  assign out_valid = ov_r;
  assign out_data  = res_r;

  // modular helpers over slot indices
  function automatic logic [SLOT_W-1:0] wrap_add(input logic [5:0] a,
                                                 input logic [4:0] m);
    logic [5:0] t;
    t = (a >= {1'b0, m}) ? a - {1'b0, m} : a;
    return t[SLOT_W-1:0];
  endfunction

  logic [SLOT_W-1:0] last_idx, old_idx;
  assign last_idx = wrap_add({2'b0, head_r} + {1'b0, slots_r} - 6'd1, slots_r);
  assign old_idx  = wrap_add({2'b0, head_r} + {1'b0, free_s_r}, slots_r);

  logic [63:0] rs;
  logic [SLOT_W-1:0] nx;
  assign rs = rseq_r[cmd_r.reader];
  assign nx = rnx_r[cmd_r.reader];

  logic [13:0] fb_sum;
  logic [12:0] fb_rel;
  assign fb_sum = {1'b0, free_b_r} + {1'b0, rd.len};
  assign fb_rel = (fb_sum > {1'b0, bytes_r}) ? bytes_r : fb_sum[12:0];

  logic [12:0] wp_sum;
  logic [11:0] wp_next;
  assign wp_sum  = {1'b0, wp_r} + cmd_r.length;
  assign wp_next = (wp_sum >= bytes_r) ? 12'(wp_sum - bytes_r) : wp_sum[11:0];

  logic [4:0] cfg_clamp;
  assign cfg_clamp = (cfg_data[4:0] == 5'd0) ? 5'd1 :
                     (cfg_data[4:0] > 5'(SLOT_DEPTH)) ? 5'(SLOT_DEPTH) : cfg_data[4:0];
  logic [12:0] cfg_bclamp;
  assign cfg_bclamp = (cfg_data == 13'd0) ? 13'd1 :
                      (cfg_data > 13'(DATA_DEPTH)) ? 13'(DATA_DEPTH) : cfg_data;

  // puts rejected at the input get their result at the transfer
  frdm_out_t in_res;
  logic      in_rej;
  always_comb begin
    in_res = '0;
    in_rej = 1'b0;
    if (in_data.kind == KIND_PUT) begin
      if (in_data.length == 13'd0) begin
        in_res.status = ST_BADLEN; in_rej = 1'b1;
      end else if (in_data.length > bytes_r) begin
        in_res.status = ST_OVERFLOW; in_res.frame_len = in_data.length; in_rej = 1'b1;
      end
    end
  end

  // put walk control
  logic hdone, wdone, put_commit, walk_stop_pre;
  logic [12:0] fb_h;
  logic [4:0]  fs_h;
  logic [SLOT_W-1:0] old_idx_h;
  assign fb_h = (free_s_r == 5'd0 && rd.seq != 64'd0) ? fb_rel : free_b_r;
  assign fs_h = (free_s_r == 5'd0 && rd.seq != 64'd0) ? 5'd1 : free_s_r;
  assign old_idx_h = wrap_add({2'b0, head_r} + {1'b0, fs_h}, slots_r);
  // after head check, decide whether walk is needed
  assign walk_stop_pre = (fb_h >= cmd_r.length) || (old_idx_h == head_r);
  assign hdone = (st_r == S_HCHK) && walk_stop_pre;
  // in walk check: release current slot if occupied, then test stop
  logic [12:0] fb_w;
  logic [4:0]  fs_w;
  logic [SLOT_W-1:0] wi_n;
  assign fb_w = (rd.seq != 64'd0) ? fb_rel : free_b_r;
  assign fs_w = (rd.seq != 64'd0 && free_s_r < slots_r) ? free_s_r + 5'd1 : free_s_r;
  assign wi_n = wrap_add({2'b0, wi_r} + 6'd1, slots_r);
  assign wdone = (st_r == S_WCHK) &&
                 ((fb_w >= cmd_r.length) || (wi_n == head_r) ||
                  (walk_r + 5'd1 >= slots_r));
  logic [12:0] fb_f;
  logic [4:0]  fs_f, ev_f;
  always_comb begin
    if (st_r == S_HCHK) begin
      fb_f = fb_h; fs_f = fs_h;
      ev_f = (free_s_r == 5'd0) ? 5'd1 : 5'd0;
    end else begin
      fb_f = fb_w; fs_f = fs_w;
      ev_f = ev_r + ((rd.seq != 64'd0) ? 5'd1 : 5'd0);
    end
  end
  assign put_commit = (hdone || wdone) && (fb_f >= cmd_r.length) && (fs_f != 5'd0);

  // get selection
  logic [SLOT_W-1:0] gsel;
  always_comb begin
    if (cmd_r.want_last) gsel = last_idx;
    else if ({1'b0, nx} < slots_r && st_r == S_GCHK && rd.seq == rs + 64'd1 && ri_r == nx)
      gsel = nx;
    else if (rs == newest_r) gsel = last_idx;
    else gsel = old_idx;
  end

  logic stale;
  assign stale = ((rs == newest_r) && !cmd_r.want_copy) || (newest_r == 64'd0);

  // next state and slot table accesses
  always_comb begin
    st_nxt = st_r;
    port   = '0;
    unique case (st_r)
      S_IDLE: if (in_go) begin
        if (in_data.kind == KIND_PUT) st_nxt = in_rej ? S_IDLE : S_HRD;
        else if (in_data.kind == KIND_GET) st_nxt = S_GRD;
        else st_nxt = S_GRES;
      end
      S_HRD: begin
        port.rd_en = 1'b1; port.rd_addr = head_r; st_nxt = S_HCHK;
      end
      S_HCHK: begin
        if (free_s_r == 5'd0 && rd.seq != 64'd0) begin
          port.wr_en = 1'b1; port.wr_addr = head_r;
        end
        if (hdone) st_nxt = put_commit ? S_PCOM : S_IDLE;
        else st_nxt = S_WRD;
      end
      S_WRD: begin
        port.rd_en = 1'b1; port.rd_addr = wi_r; st_nxt = S_WCHK;
      end
      S_WCHK: begin
        if (rd.seq != 64'd0) begin
          port.wr_en = 1'b1; port.wr_addr = wi_r;
        end
        if (wdone) st_nxt = put_commit ? S_PCOM : S_IDLE;
        else st_nxt = S_WRD;
      end
      // new frame goes into the head slot after the last release landed
      S_PCOM: begin
        port.wr_en = 1'b1; port.wr_addr = head_r;
        port.wr_data.seq = newest_r + 64'd1;
        port.wr_data.len = cmd_r.length;
        port.wr_data.off = wp_r;
        st_nxt = S_IDLE;
      end
      S_GRD: begin
        port.rd_en = 1'b1; port.rd_addr = ri_r; st_nxt = S_GCHK;
      end
      S_GCHK: st_nxt = (!stale && gsel != ri_r) ? S_GRD : S_IDLE;
      S_GRES: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  logic res_done;
  assign res_done = (st_r != S_IDLE && st_nxt == S_IDLE) || (in_go && in_rej);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0;
      slots_r <= 5'(SLOT_DEPTH); bytes_r <= 13'(DATA_DEPTH);
      head_r <= '0; free_s_r <= 5'(SLOT_DEPTH); wp_r <= '0;
      free_b_r <= 13'(DATA_DEPTH); newest_r <= '0;
      for (int k = 0; k < READER_COUNT; k++) begin
        rseq_r[k] <= '0; rnx_r[k] <= SLOT_W'(1);
      end
    end else begin
      st_r <= st_nxt;
      if (ov_r && out_ready) ov_r <= 1'b0;
      else if (res_done) ov_r <= 1'b1;
      if (cfg_go) begin
        if (cfg_index == CFG_SLOTS) begin
          slots_r <= cfg_clamp; free_s_r <= cfg_clamp; free_b_r <= bytes_r;
        end else begin
          bytes_r <= cfg_bclamp; free_s_r <= slots_r; free_b_r <= cfg_bclamp;
        end
        head_r <= '0; wp_r <= '0; newest_r <= '0;
        for (int k = 0; k < READER_COUNT; k++) begin
          rseq_r[k] <= '0; rnx_r[k] <= SLOT_W'(1);
        end
      end
      if (in_go) begin
        cmd_r <= in_data;
        res_r <= in_res;
        if (in_data.kind == KIND_GET) ri_r <= rnx_r[in_data.reader];
      end
      if (st_r == S_HCHK) begin
        free_b_r <= fb_h; free_s_r <= fs_h; ev_r <= ev_f;
        wi_r <= old_idx_h; walk_r <= '0;
      end
      if (st_r == S_WCHK) begin
        free_b_r <= fb_w; free_s_r <= fs_w; ev_r <= ev_f;
        wi_r <= wi_n; walk_r <= walk_r + 5'd1;
      end
      if ((hdone || wdone) && !put_commit) begin
        res_r.status <= ST_INCONS; res_r.evicted <= ev_f;
      end
      if (st_r == S_PCOM) begin
        res_r.status <= ST_OK; res_r.offset <= wp_r; res_r.evicted <= ev_r;
        res_r.frame_len <= cmd_r.length; res_r.sequence_res <= newest_r + 64'd1;
        newest_r <= newest_r + 64'd1; wp_r <= wp_next;
        free_b_r <= free_b_r - cmd_r.length; free_s_r <= free_s_r - 5'd1;
        head_r <= wrap_add({2'b0, head_r} + 6'd1, slots_r);
      end
      if (st_r == S_GCHK) begin
        if (stale) begin
          res_r.status <= ST_STALE;
        end else if (gsel != ri_r) begin
          ri_r <= gsel;
        end else begin
          if (rd.seq == 64'd0 || rs > rd.seq) res_r.status <= ST_INCONS;
          else if (rd.len > cmd_r.length) begin
            res_r.status <= ST_OVERFLOW; res_r.frame_len <= rd.len;
          end else begin
            res_r.status <= (rd.seq > rs + 64'd1) ? ST_MISSED : ST_OK;
            res_r.offset <= rd.off; res_r.frame_len <= rd.len;
            res_r.sequence_res <= rd.seq;
            rseq_r[cmd_r.reader] <= rd.seq;
            rnx_r[cmd_r.reader] <= wrap_add({2'b0, ri_r} + 6'd1, slots_r);
          end
        end
      end
      if (st_r == S_GRES) begin
        if (cmd_r.kind == KIND_FLUSH) begin
          rseq_r[cmd_r.reader] <= newest_r; rnx_r[cmd_r.reader] <= head_r;
          res_r.sequence_res <= newest_r;
        end else begin
          rseq_r[cmd_r.reader] <= '0; rnx_r[cmd_r.reader] <= SLOT_W'(1);
        end
      end
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_go |-> !ov_r) else $error("accept while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    free_s_r <= slots_r) else $error("free slot count beyond slots");
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Frame ring descriptor manager bench: directed and random commands, checked by a local model.
`timescale 1ns / 100ps
`default_nettype none

class frame_ring_scoreboard;
  int unsigned n_slots;
  int unsigned n_bytes;
  logic [63:0] s_seq [16];
  int unsigned s_len [16];
  int unsigned s_off [16];
  int unsigned head, free_sl, wp, free_b;
  logic [63:0] newest;
  logic [63:0] r_seq [4];
  int unsigned r_next [4];
  frdm_pkg::frdm_out_t pending [$];
  int errors;

  function new();
    n_slots = 16;
    n_bytes = 4096;
    errors = 0;
    clear_ring();
  endfunction

  function void clear_ring();
    for (int k = 0; k < 16; k++) begin
      s_seq[k] = 0; s_len[k] = 0; s_off[k] = 0;
    end
    head = 0; free_sl = n_slots; wp = 0; free_b = n_bytes; newest = 0;
    for (int k = 0; k < 4; k++) begin
      r_seq[k] = 0; r_next[k] = 1;
    end
  endfunction

  function void write_reg(logic idx, logic [12:0] v);
    int unsigned hi;
    int unsigned x;
    hi = (idx == frdm_pkg::CFG_SLOTS) ? 16 : 4096;
    x = (idx == frdm_pkg::CFG_SLOTS) ? 32'(v[4:0]) : 32'(v);
    if (x < 1) x = 1;
    if (x > hi) x = hi;
    if (idx == frdm_pkg::CFG_SLOTS) n_slots = x;
    else n_bytes = x;
    clear_ring();
  endfunction

  function void free_slot(int unsigned s);
    if (s_seq[s] == 0) return;
    free_b += s_len[s];
    if (free_b > n_bytes) free_b = n_bytes;
    if (free_sl < n_slots) free_sl++;
    s_seq[s] = 0; s_len[s] = 0; s_off[s] = 0;
  endfunction

  function frdm_pkg::frdm_out_t mk(int unsigned st, int unsigned off, int unsigned len,
                                   logic [63:0] sq, int unsigned ev);
    frdm_pkg::frdm_out_t o;
    o.status = st[2:0]; o.offset = off[11:0]; o.frame_len = len[12:0];
    o.sequence_res = sq; o.evicted = ev[4:0];
    return o;
  endfunction

  function frdm_pkg::frdm_out_t put_frame(int unsigned len);
    int unsigned ev, i;
    frdm_pkg::frdm_out_t o;
    ev = 0;
    if (len == 0) return mk(frdm_pkg::ST_BADLEN, 0, 0, 0, 0);
    if (len > n_bytes) return mk(frdm_pkg::ST_OVERFLOW, 0, len, 0, 0);
    if (free_sl == 0) begin
      free_slot(head); ev++;
    end
    i = (head + free_sl) % n_slots;
    for (int n = 0; n < n_slots && free_b < len; n++) begin
      if (i == head) break;
      if (s_seq[i] != 0) begin
        free_slot(i); ev++;
      end
      i = (i + 1) % n_slots;
    end
    if (free_b < len || free_sl == 0) return mk(frdm_pkg::ST_INCONS, 0, 0, 0, ev);
    newest++;
    s_seq[head] = newest; s_len[head] = len; s_off[head] = wp;
    o = mk(frdm_pkg::ST_OK, wp, len, newest, ev);
    wp = (wp + len) % n_bytes;
    free_b -= len;
    head = (head + 1) % n_slots;
    free_sl--;
    return o;
  endfunction

  function frdm_pkg::frdm_out_t get_frame(int unsigned r, int unsigned cap, bit last, bit cp);
    logic [63:0] rs;
    int unsigned nx, ri;
    bit missed;
    rs = r_seq[r]; nx = r_next[r];
    if ((rs == newest && !cp) || newest == 0) return mk(frdm_pkg::ST_STALE, 0, 0, 0, 0);
    if (last) ri = (head + n_slots - 1) % n_slots;
    else if (nx < n_slots && s_seq[nx] == rs + 64'd1) ri = nx;
    else if (rs == newest) ri = (head + n_slots - 1) % n_slots;
    else ri = (head + free_sl) % n_slots;
    if (s_seq[ri] == 0 || rs > s_seq[ri]) return mk(frdm_pkg::ST_INCONS, 0, 0, 0, 0);
    missed = s_seq[ri] > rs + 64'd1;
    if (s_len[ri] > cap) return mk(frdm_pkg::ST_OVERFLOW, 0, s_len[ri], 0, 0);
    r_seq[r] = s_seq[ri];
    r_next[r] = (ri + 1) % n_slots;
    return mk(missed ? frdm_pkg::ST_MISSED : frdm_pkg::ST_OK, s_off[ri], s_len[ri],
              s_seq[ri], 0);
  endfunction

  function void note_command(frdm_pkg::frdm_in_t c);
    frdm_pkg::frdm_out_t o;
    case (c.kind)
      frdm_pkg::KIND_PUT: o = put_frame(32'(c.length));
      frdm_pkg::KIND_GET: o = get_frame(32'(c.reader), 32'(c.length), c.want_last,
                                        c.want_copy);
      frdm_pkg::KIND_FLUSH: begin
        r_seq[c.reader] = newest; r_next[c.reader] = head;
        o = mk(frdm_pkg::ST_OK, 0, 0, newest, 0);
      end
      default: begin
        r_seq[c.reader] = 0; r_next[c.reader] = 1;
        o = mk(frdm_pkg::ST_OK, 0, 0, 0, 0);
      end
    endcase
    pending.push_back(o);
  endfunction

  function void check_result(frdm_pkg::frdm_out_t a);
    frdm_pkg::frdm_out_t e;
    if (pending.size() == 0) begin
      $error("result with nothing expected: %h", a);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (a.status !== e.status) begin
      $error("status exp %0d got %0d", e.status, a.status); errors++;
    end
    if (a.offset !== e.offset) begin
      $error("offset exp %0d got %0d", e.offset, a.offset); errors++;
    end
    if (a.frame_len !== e.frame_len) begin
      $error("frame_len exp %0d got %0d", e.frame_len, a.frame_len); errors++;
    end
    if (a.sequence_res !== e.sequence_res) begin
      $error("sequence_res exp %0d got %0d", e.sequence_res, a.sequence_res); errors++;
    end
    if (a.evicted !== e.evicted) begin
      $error("evicted exp %0d got %0d", e.evicted, a.evicted); errors++;
    end
  endfunction
endclass

module tb_top;
  import frdm_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  frdm_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  frdm_out_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [12:0] cfg_data = '0;

  frame_ring_scoreboard ring_model;
  int unsigned cycle_count = 0;
  bit hold_off = 0;
  int unsigned cur_bytes = 4096;

  always #5 clk = ~clk;

  frame_ring_descriptor_manager uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("frame_ring_descriptor_manager test failed");
      $finish;
    end
  end

  // receiver: pattern stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) ring_model.check_result(out_data);
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= (cycle_count % 23 < 5) ? 1'b0 : ($urandom_range(0, 3) != 0);
  end

  task automatic send_cmd(frdm_in_t c);
    in_valid <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ring_model.note_command(c);
  endtask

  task automatic idle_cycles(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (ring_model.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [12:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    ring_model.write_reg(idx, v);
    cfg_valid <= 1'b0;
    cur_bytes = ring_model.n_bytes;
    @(posedge clk);
  endtask

  function automatic frdm_in_t mk_cmd(logic [1:0] k, logic [1:0] r, logic [12:0] l,
                                      logic wl, logic wc);
    frdm_in_t c;
    c.kind = k; c.reader = r; c.length = l; c.want_last = wl; c.want_copy = wc;
    return c;
  endfunction

  function automatic frdm_in_t rand_cmd();
    frdm_in_t c;
    int unsigned p;
    p = $urandom_range(0, 99);
    c.reader = 2'($urandom_range(0, 3));
    c.want_last = $urandom_range(0, 3) == 0;
    c.want_copy = $urandom_range(0, 3) == 0;
    if (p < 45) begin
      c.kind = KIND_PUT;
      if ($urandom_range(0, 19) == 0) c.length = 13'($urandom());
      else c.length = 13'($urandom_range(1, (cur_bytes > 8) ? cur_bytes / 3 : cur_bytes));
    end else if (p < 88) begin
      c.kind = KIND_GET;
      c.length = ($urandom_range(0, 4) == 0) ? 13'($urandom_range(0, cur_bytes)) : 13'h1fff;
      if ($urandom_range(0, 9) == 0) c.length = 13'($urandom());
    end else begin
      c.kind = (p < 95) ? KIND_FLUSH : KIND_REOPEN;
      c.length = 13'($urandom());
    end
    return c;
  endfunction

  task automatic random_phase(int n);
    int sent;
    int burst;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && sent < n; b++) begin
        send_cmd(rand_cmd());
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 20));
    end
  endtask

  initial begin
    ring_model = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: edges of fields and special cases
    send_cmd(mk_cmd(KIND_GET, 0, 13'h1fff, 0, 0));
    send_cmd(mk_cmd(KIND_PUT, 0, 0, 0, 0));
    send_cmd(mk_cmd(KIND_PUT, 1, 13'd4097, 1, 1));
    send_cmd(mk_cmd(KIND_PUT, 2, 13'h1fff, 0, 0));
    send_cmd(mk_cmd(KIND_PUT, 0, 13'd4096, 0, 0));
    send_cmd(mk_cmd(KIND_PUT, 3, 1, 1, 1));
    send_cmd(mk_cmd(KIND_GET, 1, 0, 0, 0));
    send_cmd(mk_cmd(KIND_GET, 1, 13'h1fff, 0, 0));
    send_cmd(mk_cmd(KIND_GET, 1, 13'h1fff, 0, 0));
    send_cmd(mk_cmd(KIND_GET, 1, 13'h1fff, 0, 1));
    send_cmd(mk_cmd(KIND_GET, 2, 13'h1fff, 1, 0));
    for (int k = 0; k < 6; k++) send_cmd(mk_cmd(KIND_PUT, 0, 13'(700 + k), 0, 0));
    send_cmd(mk_cmd(KIND_GET, 3, 13'h1fff, 0, 0));
    send_cmd(mk_cmd(KIND_FLUSH, 3, 0, 0, 0));
    send_cmd(mk_cmd(KIND_GET, 3, 13'h1fff, 0, 1));
    send_cmd(mk_cmd(KIND_REOPEN, 3, 13'h1fff, 1, 1));
    send_cmd(mk_cmd(KIND_GET, 3, 13'h1fff, 0, 0));

    // long receiver hold-off while the sender keeps pushing
    hold_off = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      random_phase(40);
    join

    random_phase(400);
    write_cfg(CFG_SLOTS, 13'd1);
    write_cfg(CFG_BYTES, 13'd1);
    random_phase(150);
    write_cfg(CFG_SLOTS, 13'd0);
    write_cfg(CFG_BYTES, 13'd0);
    random_phase(100);
    write_cfg(CFG_SLOTS, 13'd4);
    write_cfg(CFG_BYTES, 13'd64);
    random_phase(350);
    write_cfg(CFG_SLOTS, 13'h1f);
    write_cfg(CFG_BYTES, 13'h1fff);
    random_phase(250);
    write_cfg(CFG_SLOTS, 13'd16);
    write_cfg(CFG_BYTES, 13'd4096);
    random_phase(400);

    drain();
    if (ring_model.errors == 0 && ring_model.pending.size() == 0)
      $display("frame_ring_descriptor_manager test passed");
    else
      $display("frame_ring_descriptor_manager test failed");
    $finish;
  end
endmodule

// ===== frame_ring_descriptor_manager.f =====
rtl/frdm_pkg.sv
rtl/frdm_slot_ram.sv
rtl/frame_ring_descriptor_manager.sv
sim/tb_top.sv
